// ===== rtl/pgt_pkg.sv =====
// Shared types and constants for the polygon point and segment test unit.
// Used by pgt_mul, pgt_datapath, pgt_ctrl and the top level; no dependencies.
package pgt_pkg;

    // Widths of the exact wide arithmetic, sized for the largest fraction width.
    localparam int WIDE_W      = 136;
    localparam int OPA_W       = 73;
    localparam int OPB_W       = 64;
    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_STEPS   = OPB_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    localparam logic [63:0] FAR_REACH     = 64'd10000000000;
    localparam logic [15:0] TOLERANCE_RST = 16'd66;
    localparam logic [2:0]  ADDR_TOLERANCE = 3'd0;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_POINT   = 2'd2,
        OP_SEGMENT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } res_t;

    // Multiply steps walked for each edge.
    typedef enum logic [3:0] {
        MOP_DEN1, MOP_DEN2, MOP_TN1, MOP_TN2,
        MOP_XN1, MOP_XN2, MOP_YN1, MOP_YN2,
        MOP_S_LO, MOP_S_HI, MOP_E_LO, MOP_E_HI
    } mop_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FETCH0, S_LOAD0, S_FETCH, S_LOADB,
        S_MUL_GO, S_MUL_WAIT, S_CHK_DEN, S_NORM, S_CHK_S, S_CHK_E,
        S_NEXT, S_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic clear;
        logic append;
        logic fetch_first;
        logic load_first;
        logic load_b;
        logic mul_start;
        logic mul_capture;
        logic norm;
        logic hit;
        logic advance;
        mop_t mop;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic den_parallel;
        logic flag;
        logic last_edge;
        logic answer;
        logic mul_done;
    } dp_status_t;

    function automatic mop_t mop_next(input mop_t m);
        mop_t r;
        unique case (m)
            MOP_DEN1: r = MOP_DEN2;
            MOP_DEN2: r = MOP_TN1;
            MOP_TN1:  r = MOP_TN2;
            MOP_TN2:  r = MOP_XN1;
            MOP_XN1:  r = MOP_XN2;
            MOP_XN2:  r = MOP_YN1;
            MOP_YN1:  r = MOP_YN2;
            MOP_YN2:  r = MOP_S_LO;
            MOP_S_LO: r = MOP_S_HI;
            MOP_S_HI: r = MOP_E_LO;
            MOP_E_LO: r = MOP_E_HI;
            MOP_E_HI: r = MOP_DEN1;
            default:  r = MOP_DEN1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/pgt_mul.sv =====
// Iterative signed multiplier, one 16-bit digit of the second operand a cycle.
// Depends on pgt_pkg for operand and product widths.
module pgt_mul
    import pgt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [OPA_W-1:0]  a,
    input  logic signed [OPB_W-1:0]  b,
    output logic                     done,
    output logic signed [WIDE_W-1:0] prod
);

    logic [OPA_W-1:0]           a_mag_reg;
    logic [OPB_W-1:0]           b_mag_reg;
    logic                       neg_reg;
    logic [WIDE_W-1:0]          acc_reg;
    logic [MUL_CNT_W-1:0]       cnt_reg;
    logic                       busy_reg;
    logic                       fin_reg;
    logic                       done_reg;
    logic signed [WIDE_W-1:0]   prod_reg;
    logic [OPA_W+MUL_DIGIT_W-1:0] pp;
    logic [WIDE_W-1:0]          acc_next;

    assign pp = a_mag_reg * b_mag_reg[cnt_reg*MUL_DIGIT_W +: MUL_DIGIT_W];
    assign acc_next = acc_reg + (WIDE_W'(pp) << (cnt_reg * MUL_DIGIT_W));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg  <= busy_reg && (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1));
            done_reg <= fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_mag_reg <= a[OPA_W-1] ? OPA_W'(-a) : OPA_W'(a);
            b_mag_reg <= b[OPB_W-1] ? OPB_W'(-b) : OPB_W'(b);
            neg_reg   <= a[OPA_W-1] ^ b[OPB_W-1];
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
        if (fin_reg)
        begin
            prod_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/pgt_datapath.sv =====
// Datapath: vertex store, probe and edge registers, exact crossing arithmetic.
// Depends on pgt_pkg and instantiates pgt_mul.
module pgt_datapath
    import pgt_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int FRAC_BITS    = 16,
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    input  logic [1:0]          operation,
    input  logic signed [31:0]  x_first,
    input  logic signed [31:0]  y_first,
    input  logic signed [31:0]  x_second,
    input  logic signed [31:0]  y_second,
    input  logic [15:0]         tolerance,
    output dp_status_t          status,
    output logic [CNT_W-1:0]    count
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic signed [63:0] FAR_FIX = $signed(FAR_REACH << FRAC_BITS);
    localparam logic signed [32:0] ONE_FIX = 33'sd1 <<< FRAC_BITS;

    logic signed [31:0] mem_x [MAX_VERTICES];
    logic signed [31:0] mem_y [MAX_VERTICES];
    logic signed [31:0] rd_x_q;
    logic signed [31:0] rd_y_q;

    op_t                op_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [AW-1:0]      edge_idx_reg;
    logic               answer_reg;
    logic               flag_reg;

    logic signed [31:0] sax_reg, say_reg, sby_reg;
    logic signed [63:0] sbx_reg;
    logic signed [32:0] sdx_reg, sdy_reg;
    logic signed [31:0] eax_reg, eay_reg, ebx_reg, eby_reg;

    logic signed [WIDE_W-1:0] t1_reg, den_reg, tn_reg, xn_reg, yn_reg;

    logic [CNT_W-1:0]   idx_inc;
    logic [AW-1:0]      next_idx;
    logic [AW-1:0]      rd_addr;
    logic               last_edge;

    logic signed [32:0] edx, edy, dax, day;
    logic [32:0]        edx_mag;
    logic signed [63:0] sxd;
    logic [63:0]        sxd_mag;
    logic               s_use_x, e_use_x, pick_x;
    logic signed [63:0] s_lo, s_hi, e_lo, e_hi;
    logic [WIDE_W-1:0]  den_mag, thr;
    logic signed [WIDE_W-1:0] n_sel;

    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic                     mul_done;
    logic signed [WIDE_W-1:0] prod;

    pgt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    assign idx_inc   = CNT_W'(edge_idx_reg) + 1'b1;
    assign last_edge = (idx_inc == count_reg);
    assign next_idx  = last_edge ? '0 : AW'(idx_inc);
    assign rd_addr   = cmd.fetch_first ? '0 : next_idx;

    always_comb
    begin
        edx     = 33'(ebx_reg) - 33'(eax_reg);
        edy     = 33'(eby_reg) - 33'(eay_reg);
        dax     = 33'(eax_reg) - 33'(sax_reg);
        day     = 33'(eay_reg) - 33'(say_reg);
        edx_mag = edx[32] ? 33'(-edx) : 33'(edx);
        sxd     = sbx_reg - 64'(sax_reg);
        sxd_mag = sxd[63] ? 64'(-sxd) : 64'(sxd);
        s_use_x = sxd_mag > 64'(tolerance);
        e_use_x = edx_mag > 33'(tolerance);
        if (s_use_x)
        begin
            s_lo = (64'(sax_reg) < sbx_reg) ? 64'(sax_reg) : sbx_reg;
            s_hi = (64'(sax_reg) < sbx_reg) ? sbx_reg : 64'(sax_reg);
        end
        else
        begin
            s_lo = (say_reg < sby_reg) ? 64'(say_reg) : 64'(sby_reg);
            s_hi = (say_reg < sby_reg) ? 64'(sby_reg) : 64'(say_reg);
        end
        if (e_use_x)
        begin
            e_lo = (eax_reg < ebx_reg) ? 64'(eax_reg) : 64'(ebx_reg);
            e_hi = (eax_reg < ebx_reg) ? 64'(ebx_reg) : 64'(eax_reg);
        end
        else
        begin
            e_lo = (eay_reg < eby_reg) ? 64'(eay_reg) : 64'(eby_reg);
            e_hi = (eay_reg < eby_reg) ? 64'(eby_reg) : 64'(eay_reg);
        end
        pick_x  = (cmd.mop == MOP_S_LO || cmd.mop == MOP_S_HI) ? s_use_x : e_use_x;
        n_sel   = pick_x ? xn_reg : yn_reg;
        den_mag = den_reg[WIDE_W-1] ? WIDE_W'(-den_reg) : WIDE_W'(den_reg);
        thr     = WIDE_W'(tolerance) << FRAC_BITS;
    end

    // Operand selection for each multiply step.
    always_comb
    begin
        unique case (cmd.mop)
            MOP_DEN1: begin mul_a = OPA_W'(edy);    mul_b = OPB_W'(sdx_reg); end
            MOP_DEN2: begin mul_a = OPA_W'(edx);    mul_b = OPB_W'(sdy_reg); end
            MOP_TN1:  begin mul_a = OPA_W'(dax);    mul_b = OPB_W'(edy);     end
            MOP_TN2:  begin mul_a = OPA_W'(day);    mul_b = OPB_W'(edx);     end
            MOP_XN1:  begin mul_a = OPA_W'(den_reg); mul_b = OPB_W'(sax_reg); end
            MOP_XN2:  begin mul_a = OPA_W'(tn_reg); mul_b = OPB_W'(sdx_reg); end
            MOP_YN1:  begin mul_a = OPA_W'(den_reg); mul_b = OPB_W'(say_reg); end
            MOP_YN2:  begin mul_a = OPA_W'(tn_reg); mul_b = OPB_W'(sdy_reg); end
            MOP_S_LO: begin mul_a = OPA_W'(den_reg); mul_b = s_lo;           end
            MOP_S_HI: begin mul_a = OPA_W'(den_reg); mul_b = s_hi;           end
            MOP_E_LO: begin mul_a = OPA_W'(den_reg); mul_b = e_lo;           end
            MOP_E_HI: begin mul_a = OPA_W'(den_reg); mul_b = e_hi;           end
            default:  begin mul_a = '0;             mul_b = '0;              end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem_x[AW'(count_reg)] <= sax_reg;
            mem_y[AW'(count_reg)] <= say_reg;
        end
        rd_x_q <= mem_x[rd_addr];
        rd_y_q <= mem_y[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            op_reg     <= OP_CLEAR;
            answer_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                op_reg     <= op_t'(operation);
                answer_reg <= 1'b0;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.hit)
            begin
                answer_reg <= (op_reg == OP_POINT) ? ~answer_reg : 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sax_reg <= x_first;
            say_reg <= y_first;
            if (op_t'(operation) == OP_POINT)
            begin
                sbx_reg <= FAR_FIX;
                sby_reg <= y_first;
                sdx_reg <= ONE_FIX;
                sdy_reg <= '0;
            end
            else
            begin
                sbx_reg <= 64'(x_second);
                sby_reg <= y_second;
                sdx_reg <= 33'(x_second) - 33'(x_first);
                sdy_reg <= 33'(y_second) - 33'(y_first);
            end
        end
        if (cmd.load_first)
        begin
            eax_reg      <= rd_x_q;
            eay_reg      <= rd_y_q;
            edge_idx_reg <= '0;
        end
        if (cmd.load_b)
        begin
            ebx_reg <= rd_x_q;
            eby_reg <= rd_y_q;
        end
        if (cmd.advance)
        begin
            eax_reg      <= ebx_reg;
            eay_reg      <= eby_reg;
            edge_idx_reg <= next_idx;
        end
        if (cmd.mul_capture)
        begin
            unique case (cmd.mop)
                MOP_DEN1, MOP_TN1, MOP_XN1, MOP_YN1: t1_reg <= prod;
                MOP_DEN2: den_reg <= t1_reg - prod;
                MOP_TN2:  tn_reg  <= t1_reg - prod;
                MOP_XN2:  xn_reg  <= t1_reg + prod;
                MOP_YN2:  yn_reg  <= t1_reg + prod;
                MOP_S_LO, MOP_E_LO: flag_reg <= prod < n_sel;
                MOP_S_HI, MOP_E_HI: flag_reg <= flag_reg && (n_sel < prod);
                default: ;
            endcase
        end
        // Make the denominator positive so the range checks need no sign cases.
        if (cmd.norm && den_reg[WIDE_W-1])
        begin
            den_reg <= -den_reg;
            xn_reg  <= -xn_reg;
            yn_reg  <= -yn_reg;
        end
    end

    assign status.op           = op_reg;
    assign status.empty        = (count_reg == '0);
    assign status.full         = (count_reg == CNT_W'(MAX_VERTICES));
    assign status.den_parallel = (den_mag <= thr);
    assign status.flag         = flag_reg;
    assign status.last_edge    = last_edge;
    assign status.answer       = answer_reg;
    assign status.mul_done     = mul_done;
    assign count               = count_reg;

endmodule

// ===== rtl/pgt_ctrl.sv =====
// Controller: sequences each item over the edges and multiply steps.
// Depends on pgt_pkg; drives pgt_datapath by command and reads its status.
module pgt_ctrl
    import pgt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_free,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       finish,
    output res_t       res
);

    state_t state_reg, state_next;
    mop_t   mop_reg, mop_next_v;
    res_t   res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mop_reg   <= MOP_DEN1;
            res_reg   <= RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            mop_reg   <= mop_next_v;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mop_next_v = mop_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.mop    = mop_reg;
        in_ready   = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    res_next   = RES_OK;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (status.op == OP_CLEAR)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (status.op == OP_APPEND)
                begin
                    if (status.full)
                    begin
                        res_next = RES_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else if (status.empty)
                begin
                    res_next   = RES_EMPTY;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_FETCH0;
                end
            end
            S_FETCH0:
            begin
                cmd.fetch_first = 1'b1;
                state_next      = S_LOAD0;
            end
            S_LOAD0:
            begin
                cmd.load_first = 1'b1;
                state_next     = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_LOADB;
            end
            S_LOADB:
            begin
                cmd.load_b = 1'b1;
                mop_next_v = MOP_DEN1;
                state_next = S_MUL_GO;
            end
            S_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_capture = 1'b1;
                    mop_next_v      = mop_next(mop_reg);
                    unique case (mop_reg)
                        MOP_DEN2: state_next = S_CHK_DEN;
                        MOP_YN2:  state_next = S_NORM;
                        MOP_S_HI: state_next = S_CHK_S;
                        MOP_E_HI: state_next = S_CHK_E;
                        default:  state_next = S_MUL_GO;
                    endcase
                end
            end
            S_CHK_DEN:
            begin
                state_next = status.den_parallel ? S_NEXT : S_MUL_GO;
            end
            S_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = S_MUL_GO;
            end
            S_CHK_S:
            begin
                state_next = status.flag ? S_MUL_GO : S_NEXT;
            end
            S_CHK_E:
            begin
                cmd.hit    = status.flag;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                cmd.advance = 1'b1;
                if (status.last_edge || (status.op == OP_SEGMENT && status.answer))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// ===== rtl/polygon_point_and_segment_test_unit.sv =====
// Top level of the polygon point and segment test unit: stream ports, APB register, output beat.
// Depends on pgt_pkg and instantiates pgt_ctrl and pgt_datapath.
//
// The unit holds a closed polygon of up to MAX_VERTICES vertices and takes one input beat at a
// time: clear, append a vertex, test a point (ray cast to the right, odd crossings mean inside)
// or test a segment against every edge. For each edge the exact crossing test runs up to twelve
// multiplications through one shared iterative multiplier that handles a 16-bit digit per
// cycle; an edge parallel to the probe stops after the two denominator products. A segment
// test stops at its first crossing. The result beat sits in an output register, so the next
// input beat is taken while it waits.
module polygon_point_and_segment_test_unit
    import pgt_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int FRAC_BITS    = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_first [31:0], y_first [63:32], x_second [95:64], y_second [127:96]
    input  logic [127:0] s_tdata,
    // operation [1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // answer [0], status [2:1], vertex_total [9:3], zero fill [15:10]
    output logic [15:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [15:0]      tolerance_reg;
    logic             out_valid_reg;
    logic [15:0]      out_data_reg;
    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [CNT_W-1:0] count;
    logic [CNT_W+6:0] count_ext;
    logic             finish;
    res_t             res;
    logic             out_free;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_TOLERANCE[2]) ? {16'd0, tolerance_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOLERANCE_RST;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == ADDR_TOLERANCE[2])
        begin
            tolerance_reg <= pwdata[15:0];
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign count_ext = {7'd0, count};

    pgt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .finish   (finish),
        .res      (res)
    );

    pgt_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .FRAC_BITS    (FRAC_BITS),
        .CNT_W        (CNT_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (s_tuser),
        .x_first   (s_tdata[31:0]),
        .y_first   (s_tdata[63:32]),
        .x_second  (s_tdata[95:64]),
        .y_second  (s_tdata[127:96]),
        .tolerance (tolerance_reg),
        .status    (status),
        .count     (count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= {6'd0, count_ext[6:0], res, status.answer};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== test/tb_polygon_point_and_segment_test_unit.sv =====
// Self-checking testbench for polygon_point_and_segment_test_unit: drives vertex, point and
// segment beats, predicts every result beat and compares it. Depends on pgt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_polygon_point_and_segment_test_unit;
    import pgt_pkg::*;

    localparam int DEPTH       = 64;
    localparam int FRAC        = 16;
    localparam int STALL_LIMIT = 50000;
    localparam int ONE         = 65536;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        op_t                op;
        logic signed [31:0] x1, y1, x2, y2;
    } beat_t;

    typedef struct {
        longint ax, ay, bx, by, dx, dy;
    } piece_t;

    typedef struct {
        logic       answer;
        res_t       status;
        logic [6:0] total;
    } verdict_t;

    class polygon_scoreboard;
        logic signed [31:0] vx [DEPTH];
        logic signed [31:0] vy [DEPTH];
        int                 count;
        int unsigned        tol;
        verdict_t           pending_q [$];
        int                 errors;
        int                 results_seen;

        function new();
            count = 0;
            tol = TOLERANCE_RST;
            errors = 0;
            results_seen = 0;
        endfunction

        function piece_t make_piece(longint ax, longint ay, longint bx, longint by);
            piece_t p;
            p.ax = ax; p.ay = ay; p.bx = bx; p.by = by;
            p.dx = bx - ax; p.dy = by - ay;
            return p;
        endfunction

        function bit between(longint lo, longint hi, wide_t n, wide_t den);
            wide_t l, h;
            l = lo;
            h = hi;
            return (l * den < n) && (n < h * den);
        endfunction

        function bit piece_holds(piece_t p, wide_t xn, wide_t yn, wide_t den);
            longint xa, xb, ya, yb;
            xa = (p.ax < p.bx) ? p.ax : p.bx;
            xb = (p.ax < p.bx) ? p.bx : p.ax;
            ya = (p.ay < p.by) ? p.ay : p.by;
            yb = (p.ay < p.by) ? p.by : p.ay;
            if (xb - xa > longint'(tol))
                return between(xa, xb, xn, den);
            return between(ya, yb, yn, den);
        endfunction

        function bit crosses(piece_t s, piece_t e);
            wide_t sdx, sdy, edx, edy, sax, say, eax, eay, den, mag, thr, tn, xn, yn;
            sdx = s.dx; sdy = s.dy; edx = e.dx; edy = e.dy;
            sax = s.ax; say = s.ay; eax = e.ax; eay = e.ay;
            den = sdx * edy - sdy * edx;
            mag = (den < 0) ? -den : den;
            thr = longint'(tol) << FRAC;
            if (mag <= thr)
                return 0;
            tn = (eax - sax) * edy - (eay - say) * edx;
            xn = sax * den + tn * sdx;
            yn = say * den + tn * sdy;
            if (den < 0)
            begin
                den = -den;
                xn = -xn;
                yn = -yn;
            end
            return piece_holds(s, xn, yn, den) && piece_holds(e, xn, yn, den);
        endfunction

        function piece_t edge_piece(int i);
            int j;
            j = (i + 1 == count) ? 0 : i + 1;
            return make_piece(vx[i], vy[i], vx[j], vy[j]);
        endfunction

        function void note_input(beat_t b);
            verdict_t v;
            piece_t   probe;
            int       hits;
            v.answer = 0;
            v.status = RES_OK;
            if (b.op == OP_CLEAR)
                count = 0;
            else if (b.op == OP_APPEND)
            begin
                if (count < DEPTH)
                begin
                    vx[count] = b.x1;
                    vy[count] = b.y1;
                    count++;
                end
                else
                    v.status = RES_FULL;
            end
            else if (count == 0)
                v.status = RES_EMPTY;
            else if (b.op == OP_POINT)
            begin
                probe.ax = b.x1; probe.ay = b.y1;
                probe.bx = longint'(FAR_REACH) << FRAC; probe.by = b.y1;
                probe.dx = longint'(1) << FRAC; probe.dy = 0;
                hits = 0;
                for (int i = 0; i < count; i++)
                    if (crosses(probe, edge_piece(i)))
                        hits++;
                v.answer = hits[0];
            end
            else
            begin
                probe = make_piece(b.x1, b.y1, b.x2, b.y2);
                for (int i = 0; i < count && !v.answer; i++)
                    if (crosses(probe, edge_piece(i)))
                        v.answer = 1;
            end
            v.total = count[6:0];
            pending_q.push_back(v);
        endfunction

        function void check(logic [15:0] data);
            verdict_t v;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                $error("result beat 0x%h arrived with nothing expected", data);
                errors++;
                return;
            end
            v = pending_q.pop_front();
            if (data[0] !== v.answer)
            begin
                $error("answer: expected %0d, actual %0d", v.answer, data[0]);
                errors++;
            end
            if (data[2:1] !== v.status)
            begin
                $error("status: expected %0d, actual %0d", v.status, data[2:1]);
                errors++;
            end
            if (data[9:3] !== v.total)
            begin
                $error("vertex_total: expected %0d, actual %0d", v.total, data[9:3]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    polygon_scoreboard sb;
    int send_idle;
    int recv_idle;
    int hold_cycles;
    int stall_count;
    int beats_sent;
    int tests_sent;

    polygon_point_and_segment_test_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // The receiver decides its ready at each falling edge; a long hold-off overrides it.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("tb_polygon_point_and_segment_test_unit: errors");
            $finish;
        end
    end

    task automatic send_beat(input beat_t b);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.op;
        s_tdata  <= {b.y2, b.x2, b.y1, b.x1};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(b);
        beats_sent++;
        if (b.op == OP_POINT || b.op == OP_SEGMENT)
            tests_sent++;
        @(negedge clk);
    endtask

    task automatic send_op(input op_t op, input int x1, input int y1,
                           input int x2 = 0, input int y2 = 0);
        beat_t b;
        b.op = op;
        b.x1 = x1; b.y1 = y1; b.x2 = x2; b.y2 = y2;
        send_beat(b);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOLERANCE;
        pwdata  <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.tol = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly coordinates near the origin so that tests hit edges; sometimes the full range.
    function automatic int rand_coord();
        if ($urandom_range(99) < 80)
            return $signed($urandom_range(0, 20 * ONE)) - 10 * ONE;
        return $urandom;
    endfunction

    task automatic send_polygon(input int n);
        send_op(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        repeat (n)
            send_op(OP_APPEND, rand_coord(), rand_coord(), $urandom, $urandom);
    endtask

    task automatic send_tests(input int n);
        repeat (n)
        begin
            if ($urandom_range(1))
                send_op(OP_POINT, rand_coord(), rand_coord(), $urandom, $urandom);
            else
                send_op(OP_SEGMENT, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic run_random(input int quota);
        int target;
        target = beats_sent + quota;
        while (beats_sent < target)
        begin
            if ($urandom_range(99) < 85)
            begin
                send_polygon(($urandom_range(99) < 10) ? $urandom_range(1, 2)
                                                       : $urandom_range(3, 8));
                send_tests($urandom_range(2, 6));
            end
            else
                send_op(op_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // A store filled past capacity: the extra appends are dropped and flagged.
    task automatic run_full();
        send_polygon(DEPTH + 2);
        send_tests(2);
    endtask

    task automatic run_directed();
        send_op(OP_CLEAR, 0, 0);
        send_op(OP_POINT, 0, 0);
        send_op(OP_SEGMENT, 0, 0, ONE, ONE);
        send_op(OP_APPEND, 0, 0);
        send_op(OP_POINT, -ONE, 0);
        send_op(OP_SEGMENT, -ONE, -ONE, ONE, ONE);
        send_op(OP_APPEND, 4 * ONE, 0);
        send_op(OP_POINT, ONE, -ONE);
        send_op(OP_SEGMENT, 2 * ONE, -ONE, 2 * ONE, ONE);
        send_op(OP_APPEND, 4 * ONE, 4 * ONE);
        send_op(OP_APPEND, 0, 4 * ONE);
        send_op(OP_POINT, 2 * ONE, 2 * ONE, -1, -1);
        send_op(OP_POINT, 5 * ONE, 2 * ONE);
        send_op(OP_POINT, -3 * ONE, 2 * ONE);
        // A ray running along the top edge is parallel to it and skips it.
        send_op(OP_POINT, 2 * ONE, 4 * ONE);
        send_op(OP_POINT, 32'h7fffffff, 32'h7fffffff);
        send_op(OP_POINT, 32'h80000000, 32'h80000000);
        send_op(OP_SEGMENT, ONE, ONE, 3 * ONE, 3 * ONE);
        send_op(OP_SEGMENT, -ONE, 2 * ONE, 5 * ONE, 2 * ONE);
        send_op(OP_SEGMENT, 0, 0, 4 * ONE, 0);
        send_op(OP_SEGMENT, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_op(OP_APPEND, 32'h7fffffff, 32'h80000000);
        send_op(OP_POINT, 2 * ONE, 2 * ONE);
        send_op(OP_CLEAR, -1, -1, -1, -1);
    endtask

    initial
    begin
        sb = new();
        send_idle   = 30;
        recv_idle   = 56;
        hold_cycles = 0;
        stall_count = 0;
        beats_sent  = 0;
        tests_sent  = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_CLEAR;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_tolerance(TOLERANCE_RST);
        run_directed();
        run_random(200);
        drain();

        send_idle = 56;
        recv_idle = 30;
        write_tolerance(16'd0);
        run_full();
        run_random(200);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_tolerance(16'hffff);
        // Hold the receiver off while the sender keeps offering beats.
        hold_cycles = 3000;
        run_random(200);
        drain();

        write_tolerance($urandom_range(1, 16'hfffe));
        run_random(200);
        drain();

        $display("Sent %0d beats (%0d point or segment tests), checked %0d results,",
                 beats_sent, tests_sent, sb.results_seen);
        $display("over four tolerance settings and three idling patterns.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb_polygon_point_and_segment_test_unit: clean");
        else
            $display("tb_polygon_point_and_segment_test_unit: errors");
        $finish;
    end

endmodule
